[rtl/rph_pkg.sv]
// package for radius password hiding: md5 constants, sizes and helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rph_pkg;
  localparam int SECRET_MAX_BYTES = 48;
  localparam int BLOCK_BYTES = 16;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET_LEN = 3'd6;

  typedef logic [7:0] byte_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] r;
    begin
      case ({i[5:4], i[1:0]})
        4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
        4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
        4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
        4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15;
        default: r = 5'd21;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

[rtl/rph_if.sv]
// valid/ready channel interfaces for the input and output items
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface rph_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [7:0] in_byte;
  logic in_last;
  modport source (output valid, cmd, in_byte, in_last, input ready);
  modport sink (input valid, cmd, in_byte, in_last, output ready);
endinterface

interface rph_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic out_last;
  modport source (output valid, out_byte, out_last, input ready);
  modport sink (input valid, out_byte, out_last, output ready);
endinterface
`default_nettype wire

[rtl/rph_md5.sv]
// md5 compression engine: one round per cycle while init is low, over a 16-word message memory
// uses rph_pkg; message words are loaded by the caller one at a time
`timescale 1ns / 1ps
`default_nettype none
module rph_md5 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [3:0]  wr_addr,
  input  wire logic [31:0] wr_data,
  input  wire logic        init,     // load standard iv into state
  input  wire logic        start,    // run 64 rounds on the current message
  output logic             busy,
  output logic [127:0]     digest
);
  import rph_pkg::*;

  logic [31:0] msg [16];
  logic [31:0] h0, h1, h2, h3, a, b, c, d;
  logic [5:0]  rnd;
  logic [31:0] w;
  logic [3:0]  g;
  logic [31:0] f, sum, rot;
  logic [4:0]  s;

  always_ff @(posedge clk) begin
    if (wr_en) msg[wr_addr] <= wr_data;
  end

  always_comb begin
    case (rnd[5:4])
      2'd0: begin f = (b & c) | (~b & d); g = rnd[3:0]; end
      2'd1: begin f = (d & b) | (~d & c); g = 4'(5 * rnd + 1); end
      2'd2: begin f = b ^ c ^ d; g = 4'(3 * rnd + 5); end
      default: begin f = c ^ (b | ~d); g = 4'(7 * rnd); end
    endcase
    w = msg[g];
    s = md5_rot(rnd);
    sum = a + f + md5_k(rnd) + w;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd <= '0;
    end else if (init) begin
      h0 <= 32'h67452301; h1 <= 32'hefcdab89; h2 <= 32'h98badcfe; h3 <= 32'h10325476;
    end else if (start && !busy) begin
      busy <= 1'b1;
      rnd <= '0;
      a <= h0; b <= h1; c <= h2; d <= h3;
    end else if (busy) begin
      a <= d; d <= c; c <= b; b <= b + rot;
      rnd <= rnd + 6'd1;
      if (rnd == 6'd63) begin
        busy <= 1'b0;
        h0 <= h0 + d; h1 <= h1 + b + rot; h2 <= h2 + b; h3 <= h3 + c;
      end
    end
  end

  assign digest = {h3, h2, h1, h0};
endmodule
`default_nettype wire

[rtl/radius_password_hiding.sv]
// radius user-password hiding: md5(secret || chain) keystream xor, with chaining
// top level; uses rph_pkg, rph_if and rph_md5
//
// channels: in_ch (cmd, in_byte, in_last) and out_ch (out_byte, out_last),
// both valid/ready; cfg_we/cfg_index/cfg_data writes the secret registers.
// cmd 0 items shift the authenticator into the iv and restart the chain.
// cmd 1 items gather password bytes; a full block or the last byte closes it.
// a closed block loads the md5 message one word per cycle,
// then runs 64 rounds on the shared round unit; a secret over 39 bytes
// needs a second block, which is then loaded and run in turn.
// the 16 hidden bytes then leave one per cycle from the output register;
// a stalled receiver just holds the block, no item is accepted meanwhile.
// items that do not close a block leave the block in ST_IDLE, ready for the next item.
// reset (rst, synchronous) clears iv, chain, fill count and the secret.
`timescale 1ns / 1ps
`default_nettype none
module radius_password_hiding #(
  parameter int SECRET_MAX = rph_pkg::SECRET_MAX_BYTES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rph_pkg::CFG_W-1:0]     cfg_data,
  rph_in_if.sink                             in_ch,
  rph_out_if.source                          out_ch
);
  import rph_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0, ST_LOAD = 3'd1, ST_RUN = 3'd2,
                         ST_WAIT = 3'd3, ST_OUT = 3'd4;

  logic [63:0]  secret [6];
  logic [5:0]   secret_len;
  logic [127:0] iv, chain, blk;
  logic [127:0] blk_next;
  logic [3:0]   fill;
  logic         last;
  logic [2:0]   state;
  logic [4:0]   widx;     // message word being loaded
  logic         second;   // working on the second md5 block
  logic [3:0]   oidx;
  logic [127:0] cipher;

  logic [6:0]   len, n, total;
  logic         two_blk;
  logic         md_wr, md_init, md_start, md_busy;
  logic [31:0]  md_word;
  logic [127:0] digest;

  assign len = (secret_len > 6'(SECRET_MAX)) ? 7'(SECRET_MAX) : {1'b0, secret_len};
  assign n = len + 7'd16;
  assign two_blk = (n > 7'd55);
  assign total = two_blk ? 7'd127 : 7'd63;

  // message byte at position p of the padded stream
  function automatic logic [7:0] msg_byte(input logic [6:0] p);
    logic [63:0] sw;
    logic [6:0]  q;
    logic [9:0]  bits;
    begin
      sw = secret[p[5:3] > 3'd5 ? 3'd5 : p[5:3]];
      q = p - len;
      bits = {n, 3'b000};
      if (p < len) msg_byte = sw[8*(7-p[2:0]) +: 8];
      else if (p < n) msg_byte = chain[8*q[3:0] +: 8];
      else if (p == n) msg_byte = 8'h80;
      else if (p == total - 7'd7) msg_byte = bits[7:0];
      else if (p == total - 7'd6) msg_byte = {6'd0, bits[9:8]};
      else msg_byte = 8'h00;
    end
  endfunction

  logic [6:0] base;
  assign base = {second, widx[3:0], 2'b00};
  always_comb begin
    md_word = {msg_byte(base + 7'd3), msg_byte(base + 7'd2),
               msg_byte(base + 7'd1), msg_byte(base)};
  end
  assign md_wr = (state == ST_LOAD);

  // new byte at the fill position, zero-pad the rest of a partial block
  always_comb begin
    blk_next = blk;
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      if (4'(k) == fill) blk_next[8*k +: 8] = in_ch.in_byte;
      else if (4'(k) > fill) blk_next[8*k +: 8] = 8'h00;
    end
  end

  rph_md5 u_md5 (
    .clk, .rst, .wr_en(md_wr), .wr_addr(widx[3:0]), .wr_data(md_word),
    .init(md_init), .start(md_start), .busy(md_busy), .digest
  );

  logic acc;
  assign in_ch.ready = (state == ST_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign md_init = acc;
  assign md_start = (state == ST_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) secret[i] <= '0;
      secret_len <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_SECRET_LEN) secret_len <= cfg_data[5:0];
      else if (cfg_index < REG_SECRET_LEN) secret[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iv <= '0; chain <= '0; fill <= '0;
      widx <= '0; second <= 1'b0; oidx <= '0; last <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (!in_ch.cmd) begin
              iv <= {in_ch.in_byte, iv[127:8]};
              chain <= {in_ch.in_byte, iv[127:8]};
              fill <= '0;
            end else begin
              blk <= blk_next;
              last <= in_ch.in_last;
              if (fill == 4'd15 || in_ch.in_last) begin
                fill <= '0;
                widx <= '0; second <= 1'b0;
                state <= ST_LOAD;
              end else begin
                fill <= fill + 4'd1;
              end
            end
          end
        end
        ST_LOAD: begin
          widx <= widx + 5'd1;
          if (widx == 5'd15) state <= ST_RUN;
        end
        ST_RUN: state <= ST_WAIT;
        ST_WAIT: begin
          if (!md_busy) begin
            if (two_blk && !second) begin
              second <= 1'b1; widx <= '0; state <= ST_LOAD;
            end else begin
              cipher <= blk ^ digest;
              chain <= last ? iv : (blk ^ digest);
              oidx <= '0;
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            oidx <= oidx + 4'd1;
            if (oidx == 4'd15) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.out_byte = cipher[8*oidx +: 8];
  assign out_ch.out_last = last && (oidx == 4'd15);

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while output pending");
  a_md5_done_before_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !md_busy) else $error("output while md5 running");
  a_out_advance: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && oidx != 4'd15) |=> out_ch.valid)
    else $error("hidden block cut short");
endmodule
`default_nettype wire

[tb/tb.sv]
// testbench for radius_password_hiding: md5 keystream hiding with chaining
// depends on rph_pkg, rph_if and the rtl top level
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import rph_pkg::*;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       last;
  } pw_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hidden_item_t;

  localparam int REG_WORD0 = 0;
  localparam int REG_WORD5 = 5;
  localparam int REG_UNUSED = 7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  rph_in_if in_ch ();
  rph_out_if out_ch ();

  radius_password_hiding u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] secret_q [6];
  logic [5:0] secret_len_q;
  byte_t iv_q [16];
  byte_t chain_q [16];
  byte_t block_q [16];
  int fill_q;

  pw_item_t pending_items [$];
  hidden_item_t expected_bytes [$];
  int errors = 0;
  int accepted = 0;
  int idle_pct = 37;
  bit sink_hold = 1'b0;
  bit src_pause = 1'b0;
  bit in_took = 1'b0;

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic int round_shift(input int i);
    int s [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    return s[((i >> 4) << 2) | (i & 3)];
  endfunction

  function automatic logic [31:0] round_const(input int i);
    return 32'(longint'($floor($pow(2.0, 32.0) * (($sin(i + 1.0) < 0) ?
      -$sin(i + 1.0) : $sin(i + 1.0)))));
  endfunction

  task automatic compress(inout logic [31:0] h [4], input byte_t m [128], input int base);
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    for (int i = 0; i < 16; i++)
      w[i] = {m[base + 4*i + 3], m[base + 4*i + 2], m[base + 4*i + 1], m[base + 4*i]};
    a = h[0]; b = h[1]; c = h[2]; d = h[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5*i + 1) & 15;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3*i + 5) & 15;
      end else begin
        f = c ^ (b | ~d); g = (7*i) & 15;
      end
      t = d; d = c; c = b;
      b = b + rotl(a + f + round_const(i) + w[g], round_shift(i));
      a = t;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
  endtask

  // md5(secret || chain), digest bytes little endian per word
  task automatic keystream(output byte_t ks [16]);
    byte_t m [128];
    logic [31:0] h [4];
    logic [63:0] bits;
    int len, n, total;
    len = (secret_len_q > SECRET_MAX_BYTES) ? SECRET_MAX_BYTES : secret_len_q;
    for (int k = 0; k < 128; k++) m[k] = 8'h00;
    for (int k = 0; k < len; k++) m[k] = secret_q[k >> 3][63 - 8*(k & 7) -: 8];
    for (int k = 0; k < 16; k++) m[len + k] = chain_q[k];
    n = len + 16;
    m[n] = 8'h80;
    total = (n + 9 <= 64) ? 64 : 128;
    bits = 64'(n) * 8;
    for (int k = 0; k < 8; k++) m[total - 8 + k] = bits[8*k +: 8];
    h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    compress(h, m, 0);
    if (total == 128) compress(h, m, 64);
    for (int k = 0; k < 16; k++) ks[k] = h[k >> 2][8*(k & 3) +: 8];
  endtask

  task automatic predict_hidden(input pw_item_t it);
    byte_t ks [16];
    hidden_item_t r;
    if (!it.cmd) begin
      for (int k = 0; k < 15; k++) iv_q[k] = iv_q[k + 1];
      iv_q[15] = it.data;
      chain_q = iv_q;
      fill_q = 0;
      return;
    end
    block_q[fill_q] = it.data;
    fill_q++;
    if (fill_q < 16 && !it.last) return;
    for (int k = fill_q; k < 16; k++) block_q[k] = 8'h00;
    keystream(ks);
    for (int k = 0; k < 16; k++) begin
      r.data = block_q[k] ^ ks[k];
      r.last = it.last && k == 15;
      chain_q[k] = r.data;
      expected_bytes.push_back(r);
    end
    fill_q = 0;
    if (it.last) chain_q = iv_q;
  endtask

  task automatic write_reg(input int idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_WORD5) secret_q[idx] = val;
    else if (idx == REG_SECRET_LEN) secret_len_q = val[5:0];
  endtask

  // input handshake as seen at the rising edge
  always @(posedge clk)
    in_took = !rst && in_ch.valid && in_ch.ready;

  // driver
  pw_item_t cur;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_took) begin
        predict_hidden(cur);
        accepted++;
      end
      if (in_ch.valid && !in_took) begin
        // hold the offered item
      end else if (pending_items.size() > 0 && !src_pause &&
                   $urandom_range(99, 0) >= idle_pct) begin
        cur = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cur.cmd;
        in_ch.in_byte <= cur.data;
        in_ch.in_last <= cur.last;
      end else begin
        in_ch.valid <= 1'b0;
        in_ch.cmd <= 1'($urandom_range(1, 0));
        in_ch.in_byte <= 8'($urandom_range(255, 0));
        in_ch.in_last <= 1'($urandom_range(1, 0));
      end
    end
  end

  always @(negedge clk)
    out_ch.ready <= !rst && !sink_hold && ($urandom_range(99, 0) >= idle_pct);

  // monitor
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h", out_ch.out_byte));
      end else begin
        hidden_item_t e;
        e = expected_bytes.pop_front();
        if (out_ch.out_byte !== e.data)
          report($sformatf("out_byte %02h, want %02h", out_ch.out_byte, e.data));
        if (out_ch.out_last !== e.last)
          report($sformatf("out_last %b, want %b", out_ch.out_last, e.last));
      end
    end
  end

  task automatic push_item(input logic c, input logic [7:0] d, input logic l);
    pending_items.push_back('{cmd: c, data: d, last: l});
  endtask

  task automatic push_auth(input int cnt);
    for (int k = 0; k < cnt; k++) push_item(1'b0, 8'($urandom_range(255, 0)), 1'b0);
  endtask

  task automatic push_password(input int len);
    for (int k = 0; k < len; k++)
      push_item(1'b1, 8'($urandom_range(255, 0)), k == len - 1);
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !in_ch.valid);
    wait (expected_bytes.size() == 0);
    repeat (400) @(negedge clk);
  endtask

  task automatic random_secret(input int len);
    for (int i = REG_WORD0; i <= REG_WORD5; i++)
      write_reg(i, {$urandom, $urandom});
    write_reg(REG_SECRET_LEN, 64'(len));
  endtask

  initial begin
    int n, na, np;
    in_ch.valid = 1'b0; in_ch.cmd = 1'b0; in_ch.in_byte = 8'h00; in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < 6; i++) secret_q[i] = '0;
    secret_len_q = '0;
    for (int k = 0; k < 16; k++) begin
      iv_q[k] = 8'h00; chain_q[k] = 8'h00; block_q[k] = 8'h00;
    end
    fill_q = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: zero-length secret, all-ones secret, extremes
    push_item(1'b1, 8'h00, 1'b1);
    drain();
    for (int i = REG_WORD0; i <= REG_WORD5; i++) write_reg(i, '1);
    write_reg(REG_SECRET_LEN, 64'(SECRET_MAX_BYTES));
    write_reg(REG_UNUSED, 64'hdead_beef);
    push_item(1'b0, 8'hff, 1'b0);
    push_item(1'b0, 8'h00, 1'b0);
    push_item(1'b1, 8'hff, 1'b0);
    push_item(1'b1, 8'h5a, 1'b0);
    // authenticator mid-password drops the partial block
    push_item(1'b0, 8'ha5, 1'b0);
    push_item(1'b1, 8'hff, 1'b1);
    drain();
    write_reg(REG_SECRET_LEN, 64'd63);
    push_item(1'b1, 8'h01, 1'b1);
    drain();

    // random: authenticator then passwords, secret changes between phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: random_secret(16);
        1: random_secret(39);
        2: random_secret(40);
        3: random_secret($urandom_range(63, 0));
        default: random_secret($urandom_range(SECRET_MAX_BYTES, 0));
      endcase
      idle_pct = (ph == 2) ? 0 : 37;
      n = 0;
      while (n < 12) begin
        if ($urandom_range(9, 0) < 8) begin
          na = $urandom_range(4, 1);
          np = $urandom_range(20, 1);
          push_auth(na);
          push_password(np);
          n += na + np;
        end else begin
          push_item(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
                    1'($urandom_range(1, 0)));
          n += 1;
        end
      end
      if (ph == 3) begin
        // receiver holds off while the sender keeps offering
        sink_hold = 1'b1;
        repeat (600) @(negedge clk);
        sink_hold = 1'b0;
      end
      if (ph == 4) begin
        // sender waits for every result before going on
        src_pause = 1'b1;
        wait (!in_ch.valid);
        wait (expected_bytes.size() == 0);
        src_pause = 1'b0;
      end
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
rtl/rph_pkg.sv
rtl/rph_if.sv
rtl/rph_md5.sv
rtl/radius_password_hiding.sv
tb/tb.sv
